// ===== hdl/psfx_pkg.sv =====
// Shared types and constants for the console font glyph expander.
// Holds the parse phases, the command format passed from front to back, and header constants.
// No dependencies.
package psfx_pkg;

    // Parse phases of the front end.
    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_MAGIC2,
        PH_V1HDR,
        PH_V2WORDS,
        PH_SKIP,
        PH_GLYPH,
        PH_BAD
    } t_phase;

    // Result kinds as they appear on the result port.
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_BAD_MAGIC = 2'd2
    } t_kind;

    // One command from the front to the back: a glyph byte with its pixel count,
    // or a single header or error result.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [3:0]  npix;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [15:0] count;
    } t_cmd;

    // Magic bytes.
    localparam logic [7:0] PSF1_MAGIC0 = 8'h36;
    localparam logic [7:0] PSF1_MAGIC1 = 8'h04;
    localparam logic [7:0] PSF2_MAGIC0 = 8'h72;
    localparam logic [7:0] PSF2_MAGIC1 = 8'hB5;
    localparam logic [7:0] PSF2_MAGIC2 = 8'h4A;
    localparam logic [7:0] PSF2_MAGIC3 = 8'h86;

    // PSF1 header values.
    localparam int         MODE_512_BIT = 0;
    localparam logic [7:0] V1_WIDTH     = 8'd8;
    localparam logic [15:0] COUNT_512   = 16'd512;
    localparam logic [15:0] COUNT_256   = 16'd256;

    // PSF2 header layout.
    localparam logic [15:0] HBC_MAGIC_SECOND = 16'd2;
    localparam logic [15:0] HBC_WORDS_START  = 16'd4;
    localparam logic [15:0] V2_HDR_END       = 16'd32;
    localparam logic [2:0]  WORD_HDR_SIZE    = 3'd1;
    localparam logic [2:0]  WORD_COUNT       = 3'd3;
    localparam logic [2:0]  WORD_BPG         = 3'd4;
    localparam logic [2:0]  WORD_HEIGHT      = 3'd5;
    localparam logic [2:0]  WORD_WIDTH       = 3'd6;

    // Command queue.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // Row divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration registers.
    localparam int          APB_ADDR_W  = 3;
    localparam logic        REG_FILL    = 1'b0;
    localparam logic        REG_CLEAR   = 1'b1;
    localparam logic [31:0] FILL_RESET  = 32'hFFFF_FFFF;
    localparam logic [31:0] CLEAR_RESET = 32'h0000_0000;

endpackage

// ===== hdl/psfx_div.sv =====
// Restoring divider that computes bytes per row as bytes per glyph over height.
// One quotient bit per cycle. Uses psfx_pkg.
module psfx_div
    import psfx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_busy,
    output logic [15:0] o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [15:0]          r_quot;
    logic [7:0]           r_rem;
    logic [7:0]           r_div;

    logic [8:0]  shifted;
    logic [8:0]  diff;
    logic        take;

    assign shifted = {r_rem, r_quot[15]};
    assign diff    = shifted - {1'b0, r_div};
    assign take    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[14:0], take};
            r_rem  <= take ? diff[7:0] : shifted[7:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== hdl/psfx_front.sv =====
// Front end: parses the font header byte by byte and turns each byte into at most one command.
// Tracks the glyph row position and hands the row division to psfx_div. Uses psfx_pkg.
module psfx_front
    import psfx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    output logic       o_wait,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_hbc, n_hbc;
    logic [31:0] r_word, n_word;
    logic [7:0]  r_mode, n_mode;
    logic [15:0] r_bpg, n_bpg;
    logic [7:0]  r_height, n_height;
    logic [7:0]  r_width, n_width;
    logic [15:0] r_count, n_count;
    logic [15:0] r_hlen, n_hlen;
    logic [7:0]  r_bpr, n_bpr;
    logic [7:0]  r_bir, n_bir;
    logic [15:0] r_big, n_big;
    logic        r_wait, n_wait;

    t_phase      e_phase;
    logic [15:0] e_hbc;
    logic [15:0] hbc_inc;
    logic [4:0]  pos;
    logic [31:0] word_or;
    logic        div_start;
    logic        div_busy;
    logic [15:0] div_quot;
    logic [10:0] col_start;
    logic [10:0] col_left;
    logic [7:0]  bir_inc;
    logic [15:0] big_inc;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        sat16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [7:0] sat8(input logic [31:0] v);
        sat8 = (|v[31:8]) ? 8'hFF : v[7:0];
    endfunction

    // A start-of-file byte sees the cleared parse state.
    assign e_phase   = i_start_of_file ? PH_MAGIC : r_phase;
    assign e_hbc     = i_start_of_file ? 16'd0 : r_hbc;
    assign hbc_inc   = e_hbc + 16'd1;
    assign pos       = r_hbc[4:0] - HBC_WORDS_START[4:0];
    assign word_or   = r_word | (32'(i_data_byte) << {pos[1:0], 3'b000});
    assign col_start = {r_bir, 3'b000};
    assign col_left  = {3'b000, r_width} - col_start;
    assign bir_inc   = r_bir + 8'd1;
    assign big_inc   = r_big + 16'd1;

    psfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_bpg),
        .i_divisor  (n_height),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            n_phase = e_phase;
            unique case (e_phase)
                PH_MAGIC: begin
                    if (e_hbc != 16'd0) begin
                        if (r_word[7:0] == PSF1_MAGIC0 && i_data_byte == PSF1_MAGIC1) begin
                            n_phase = PH_V1HDR;
                        end else if (r_word[7:0] == PSF2_MAGIC0 &&
                                     i_data_byte == PSF2_MAGIC1) begin
                            n_phase = PH_MAGIC2;
                        end else begin
                            n_phase = PH_BAD;
                        end
                    end
                end
                PH_MAGIC2: begin
                    if (r_hbc != HBC_MAGIC_SECOND) begin
                        if (r_word[7:0] == PSF2_MAGIC2 && i_data_byte == PSF2_MAGIC3) begin
                            n_phase = PH_V2WORDS;
                        end else begin
                            n_phase = PH_BAD;
                        end
                    end
                end
                PH_V1HDR: begin
                    if (r_hbc != HBC_MAGIC_SECOND) begin
                        n_phase = PH_GLYPH;
                    end
                end
                PH_V2WORDS: begin
                    if (hbc_inc >= V2_HDR_END) begin
                        n_phase = (r_hlen > V2_HDR_END) ? PH_SKIP : PH_GLYPH;
                    end
                end
                PH_SKIP: begin
                    if (hbc_inc >= r_hlen) begin
                        n_phase = PH_GLYPH;
                    end
                end
                PH_GLYPH: n_phase = PH_GLYPH;
                PH_BAD:   n_phase = PH_BAD;
                default:  n_phase = PH_MAGIC;
            endcase
        end
    end

    // Header fields, glyph position and the command for this byte.
    always_comb begin
        logic finish;
        n_hbc      = r_hbc;
        n_word     = r_word;
        n_mode     = r_mode;
        n_bpg      = r_bpg;
        n_height   = r_height;
        n_width    = r_width;
        n_count    = r_count;
        n_hlen     = r_hlen;
        n_bpr      = r_bpr;
        n_bir      = r_bir;
        n_big      = r_big;
        n_wait     = r_wait;
        finish     = 1'b0;
        div_start  = 1'b0;
        o_cmd_push = 1'b0;
        o_cmd      = '{kind: KIND_PIXEL, data: i_data_byte, npix: 4'd0,
                       width: 8'd0, height: 8'd0, count: 16'd0};

        // Pick up the row quotient once the divider is done.
        if (r_wait && !div_busy) begin
            n_wait = 1'b0;
            n_bpr  = (|div_quot[15:8]) ? 8'hFF : div_quot[7:0];
        end

        if (i_accept) begin
            n_hbc = e_hbc;
            unique case (e_phase)
                PH_MAGIC: begin
                    if (e_hbc == 16'd0) begin
                        n_word = 32'(i_data_byte);
                        n_hbc  = 16'd1;
                    end else begin
                        n_hbc = HBC_MAGIC_SECOND;
                        if (n_phase == PH_BAD) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = KIND_BAD_MAGIC;
                        end
                    end
                end
                PH_MAGIC2: begin
                    if (r_hbc == HBC_MAGIC_SECOND) begin
                        n_word = 32'(i_data_byte);
                        n_hbc  = 16'd3;
                    end else begin
                        n_hbc  = HBC_WORDS_START;
                        n_word = 32'd0;
                        if (n_phase == PH_BAD) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = KIND_BAD_MAGIC;
                        end
                    end
                end
                PH_V1HDR: begin
                    if (r_hbc == HBC_MAGIC_SECOND) begin
                        n_mode = i_data_byte;
                        n_hbc  = 16'd3;
                    end else begin
                        n_hbc    = HBC_WORDS_START;
                        n_bpg    = 16'(i_data_byte);
                        n_height = i_data_byte;
                        n_width  = V1_WIDTH;
                        n_count  = r_mode[MODE_512_BIT] ? COUNT_512 : COUNT_256;
                        finish   = 1'b1;
                    end
                end
                PH_V2WORDS: begin
                    n_word = word_or;
                    if (pos[1:0] == 2'd3) begin
                        n_word = 32'd0;
                        unique case (pos[4:2])
                            WORD_HDR_SIZE: n_hlen   = sat16(word_or);
                            WORD_COUNT:    n_count  = sat16(word_or);
                            WORD_BPG:      n_bpg    = sat16(word_or);
                            WORD_HEIGHT:   n_height = sat8(word_or);
                            WORD_WIDTH:    n_width  = sat8(word_or);
                            default:       n_word   = 32'd0;
                        endcase
                    end
                    n_hbc  = hbc_inc;
                    finish = hbc_inc >= V2_HDR_END;
                end
                PH_SKIP: begin
                    n_hbc = hbc_inc;
                end
                PH_GLYPH: begin
                    // Pixels of this byte: columns left before the glyph width, at most eight.
                    if ({3'b000, r_width} > col_start) begin
                        o_cmd.npix = (col_left >= 11'd8) ? 4'd8 : col_left[3:0];
                        o_cmd_push = 1'b1;
                    end
                    n_bir = (r_bpr == 8'd0 || bir_inc >= r_bpr) ? 8'd0 : bir_inc;
                    if (big_inc >= r_bpg) begin
                        n_big = 16'd0;
                        n_bir = 8'd0;
                    end else begin
                        n_big = big_inc;
                    end
                end
                PH_BAD: begin
                    n_hbc = r_hbc;
                end
                default: begin
                    n_hbc = r_hbc;
                end
            endcase

            if (finish) begin
                n_bir        = 8'd0;
                n_big        = 16'd0;
                o_cmd_push   = 1'b1;
                o_cmd.kind   = KIND_HEADER;
                o_cmd.width  = n_width;
                o_cmd.height = n_height;
                o_cmd.count  = n_count;
                if (n_height == 8'd0) begin
                    n_bpr = 8'd0;
                end else begin
                    div_start = 1'b1;
                    n_wait    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_hbc    <= '0;
            r_word   <= '0;
            r_mode   <= '0;
            r_bpg    <= '0;
            r_height <= '0;
            r_width  <= '0;
            r_count  <= '0;
            r_hlen   <= '0;
            r_bpr    <= '0;
            r_bir    <= '0;
            r_big    <= '0;
            r_wait   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hbc    <= n_hbc;
            r_word   <= n_word;
            r_mode   <= n_mode;
            r_bpg    <= n_bpg;
            r_height <= n_height;
            r_width  <= n_width;
            r_count  <= n_count;
            r_hlen   <= n_hlen;
            r_bpr    <= n_bpr;
            r_bir    <= n_bir;
            r_big    <= n_big;
            r_wait   <= n_wait;
        end
    end

    assign o_wait = r_wait;

endmodule

// ===== hdl/psfx_cmd_fifo.sv =====
// Short command queue between the front end and the pixel back end.
// Register array with read and write pointers and a fill count. Uses psfx_pkg.
module psfx_cmd_fifo
    import psfx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = r_count == (CMD_PTR_W + 1)'(CMD_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ===== hdl/psfx_back.sv =====
// Back end: walks the head command into the output register, one result per cycle while it is free.
// Glyph bytes yield their pixels MSB first; header and error commands yield one result. Uses psfx_pkg.
module psfx_back
    import psfx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_head_valid,
    output logic        o_head_pop,
    input  logic [31:0] i_fill,
    input  logic [31:0] i_clear,
    input  logic        i_out_pop,
    output logic        o_out_valid,
    output logic [1:0]  o_item_kind,
    output logic [31:0] o_pixel_value,
    output logic [7:0]  o_glyph_width,
    output logic [7:0]  o_glyph_height,
    output logic [15:0] o_glyph_count,
    output logic        o_last_of_run
);

    logic [2:0]  r_idx;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [31:0] r_pixel;
    logic [7:0]  r_width;
    logic [7:0]  r_height;
    logic [15:0] r_count;
    logic        r_last;

    logic advance;
    logic emit;
    logic head_last;
    logic is_pixel;

    assign advance   = !r_out_valid || i_out_pop;
    assign emit      = advance && i_head_valid;
    assign is_pixel  = i_head.kind == KIND_PIXEL;
    assign head_last = !is_pixel || ((4'(r_idx) + 4'd1) == i_head.npix);
    assign o_head_pop = emit && head_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx       <= head_last ? 3'd0 : r_idx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= i_head.kind;
            r_width  <= i_head.width;
            r_height <= i_head.height;
            r_count  <= i_head.count;
            r_last   <= head_last;
            if (is_pixel) begin
                r_pixel <= i_head.data[3'd7 - r_idx] ? i_fill : i_clear;
            end else begin
                r_pixel <= 32'd0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_item_kind    = r_kind;
    assign o_pixel_value  = r_pixel;
    assign o_glyph_width  = r_width;
    assign o_glyph_height = r_height;
    assign o_glyph_count  = r_count;
    assign o_last_of_run  = r_last;

endmodule

// ===== hdl/console_font_glyph_expander_unit.sv =====
// Each result passes through the command queue and the back end's output register.
// The input takes one byte per cycle while headers parse and the queue has room; a glyph byte
// yields up to 8 pixel results, and a four-entry command queue absorbs the difference.
// After the last header byte the input stays full while the row divider runs.
// Reset (synchronous, active low) restores the magic check and the colour register defaults.
// Top level; instantiates psfx_front, psfx_cmd_fifo and psfx_back, and uses psfx_pkg.
module console_font_glyph_expander_unit
    import psfx_pkg::*;
#(
    parameter int PIXEL_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Font byte stream, queue style.
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_start_of_file,

    // Result stream, queue style.
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_item_kind,
    output logic [31:0]           o_pixel_value,
    output logic [7:0]            o_glyph_width,
    output logic [7:0]            o_glyph_height,
    output logic [15:0]           o_glyph_count,
    output logic                  o_last_of_run,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Pixel values are cut down to the configured pixel depth.
    localparam logic [31:0] PixMask = (PIXEL_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << PIXEL_BITS) - 64'd1);

    logic [31:0] r_fill_colour;
    logic [31:0] r_clear_colour;

    logic  cfg_write;
    logic  in_accept;
    logic  out_accept;
    logic  front_wait;
    logic  cmd_push;
    t_cmd  cmd;
    logic  fifo_full;
    logic  fifo_empty;
    logic  fifo_pop;
    t_cmd  fifo_head;
    logic  out_valid;

    // The configuration port never stalls. A write lands on the access cycle; the register is
    // chosen by the word address, so the two colours sit at byte addresses 0 and 4.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_colour  <= FILL_RESET;
            r_clear_colour <= CLEAR_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_CLEAR) begin
                r_clear_colour <= pwdata;
            end else begin
                r_fill_colour <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_FILL) ? r_fill_colour : r_clear_colour;

    // A byte is taken only when the queue has room for the one command it can cause and the
    // front end is not waiting on the row divider.
    assign full       = front_wait || fifo_full;
    assign in_accept  = push && !full;
    assign out_accept = pop && !empty;

    // The front end checks the magic, decodes the header and classifies glyph bytes.
    psfx_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_wait          (front_wait),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd)
    );

    // Commands carry everything the back end needs, so a new header can be parsed while
    // pixels of the previous font are still being sent out.
    psfx_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .i_pop   (fifo_pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (fifo_head)
    );

    // The back end sends one result per cycle into its output register while that is free;
    // every transfer on the result side frees that register for the next result.
    psfx_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (fifo_head),
        .i_head_valid   (!fifo_empty),
        .o_head_pop     (fifo_pop),
        .i_fill         (r_fill_colour & PixMask),
        .i_clear        (r_clear_colour & PixMask),
        .i_out_pop      (out_accept),
        .o_out_valid    (out_valid),
        .o_item_kind    (o_item_kind),
        .o_pixel_value  (o_pixel_value),
        .o_glyph_width  (o_glyph_width),
        .o_glyph_height (o_glyph_height),
        .o_glyph_count  (o_glyph_count),
        .o_last_of_run  (o_last_of_run)
    );

    assign empty = !out_valid;

endmodule

// ===== tb/console_font_glyph_expander_unit_tb.sv =====
// Self-checking testbench for the console font glyph expander.
// Drives PSF1/PSF2 byte streams, predicts every result in-line and checks each transfer.
// Depends on psfx_pkg and console_font_glyph_expander_unit.
module console_font_glyph_expander_unit_tb;
    import psfx_pkg::*;

    // Cycle budget. The slowest legal run is roughly 450 stream bytes that each
    // cost up to 8 results, each behind a receiver stall, plus a sender gap and
    // a divider pause; this limit leaves a wide margin over such a run.
    localparam int CYCLE_LIMIT   = 400_000;
    // Quiet time after the last expected result: divider pause plus a full
    // command queue of glyph bytes that may produce no pixels.
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 40;
    localparam int FEED_SIDE     = 0;
    localparam int DRAIN_SIDE    = 1;

    // One result as it appears on the output ports.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] pixel;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [15:0] count;
        logic        last;
    } t_font_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [7:0]            i_data_byte;
    logic                  i_start_of_file;
    logic                  empty;
    logic                  pop;
    logic [1:0]            o_item_kind;
    logic [31:0]           o_pixel_value;
    logic [7:0]            o_glyph_width;
    logic [7:0]            o_glyph_height;
    logic [15:0]           o_glyph_count;
    logic                  o_last_of_run;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    console_font_glyph_expander_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results still owed by the block, oldest first.
    t_font_item  predicted_font_items[$];
    // Bytes of the font file being assembled for the next stream.
    logic [7:0]  file_bytes[$];

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int unsigned bytes_sent = 0;

    // Idle pattern state per side: stretches of back-to-back transfers
    // alternate with stretches of random gaps.
    int          calm_left[2] = '{0, 0};
    bit          calm_on[2];

    // Shadow copies of the colour registers.
    logic [31:0] fill_shadow;
    logic [31:0] clear_shadow;

    // Parser state mirrored from the block.
    t_phase      parse_state;
    logic [15:0] header_pos;
    logic [31:0] word_buf;
    logic [7:0]  psf1_mode;
    logic [15:0] glyph_size;
    logic [7:0]  glyph_rows;
    logic [7:0]  glyph_cols;
    logic [15:0] glyph_total;
    logic [15:0] header_size;
    logic [7:0]  row_stride;
    logic [7:0]  row_byte;
    logic [15:0] glyph_byte;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_wait(input int side);
        if (calm_left[side] == 0) begin
            calm_on[side] = ($urandom_range(0, 3) == 0);
            calm_left[side] = $urandom_range(8, 40);
        end
        calm_left[side]--;
        return calm_on[side] ? 0 : $urandom_range(0, 14);
    endfunction

    // Header field values: mostly small, sometimes far beyond the field widths
    // so that the saturation paths get exercised.
    function automatic logic [31:0] pick_field(input int unsigned typical_max);
        case ($urandom_range(0, 7))
            0: pick_field = $urandom;
            1: pick_field = $urandom_range(256, 70000);
            default: pick_field = $urandom_range(0, typical_max);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %0s at cycle %0d: got %h, expected %h",
                     what, cycle_count, got, want);
    endtask

    function automatic void add_expected(input t_kind kind, input logic [31:0] pixel,
                                         input logic [7:0] width, input logic [7:0] height,
                                         input logic [15:0] count, input logic last);
        t_font_item item;
        item.kind   = kind;
        item.pixel  = pixel;
        item.width  = width;
        item.height = height;
        item.count  = count;
        item.last   = last;
        predicted_font_items.push_back(item);
    endfunction

    // A start of file wipes every parse field but leaves the colours alone.
    function automatic void clear_font_state();
        parse_state = PH_MAGIC;
        header_pos  = '0;
        word_buf    = '0;
        psf1_mode   = '0;
        glyph_size  = '0;
        glyph_rows  = '0;
        glyph_cols  = '0;
        glyph_total = '0;
        header_size = '0;
        row_stride  = '0;
        row_byte    = '0;
        glyph_byte  = '0;
    endfunction

    // The header is complete: fix the row stride once and announce the font.
    function automatic void close_header();
        if (glyph_rows == 8'd0)
            row_stride = 8'd0;
        else if (glyph_size / glyph_rows > 16'd255)
            row_stride = 8'd255;
        else
            row_stride = 8'(glyph_size / glyph_rows);
        row_byte   = '0;
        glyph_byte = '0;
        add_expected(KIND_HEADER, '0, glyph_cols, glyph_rows, glyph_total, 1'b1);
    endfunction

    function automatic void reject_magic();
        parse_state = PH_BAD;
        add_expected(KIND_BAD_MAGIC, '0, '0, '0, '0, 1'b1);
    endfunction

    // Advances the mirrored parser by one accepted byte and queues whatever
    // results the block owes for it.
    function automatic void expand_font_byte(input logic [7:0] b, input logic sof);
        logic [4:0] word_pos;
        if (sof)
            clear_font_state();
        case (parse_state)
            PH_MAGIC: begin
                if (header_pos == 16'd0) begin
                    word_buf   = {24'd0, b};
                    header_pos = 16'd1;
                end else begin
                    header_pos = HBC_MAGIC_SECOND;
                    if (word_buf[7:0] == PSF1_MAGIC0 && b == PSF1_MAGIC1)
                        parse_state = PH_V1HDR;
                    else if (word_buf[7:0] == PSF2_MAGIC0 && b == PSF2_MAGIC1)
                        parse_state = PH_MAGIC2;
                    else
                        reject_magic();
                end
            end
            PH_MAGIC2: begin
                if (header_pos == HBC_MAGIC_SECOND) begin
                    word_buf   = {24'd0, b};
                    header_pos = 16'd3;
                end else begin
                    header_pos = HBC_WORDS_START;
                    if (word_buf[7:0] == PSF2_MAGIC2 && b == PSF2_MAGIC3) begin
                        word_buf    = '0;
                        parse_state = PH_V2WORDS;
                    end else begin
                        reject_magic();
                    end
                end
            end
            PH_V1HDR: begin
                if (header_pos == HBC_MAGIC_SECOND) begin
                    psf1_mode  = b;
                    header_pos = 16'd3;
                end else begin
                    // The character size doubles as both height and glyph size.
                    header_pos  = HBC_WORDS_START;
                    glyph_size  = {8'd0, b};
                    glyph_rows  = b;
                    glyph_cols  = V1_WIDTH;
                    glyph_total = psf1_mode[MODE_512_BIT] ? COUNT_512 : COUNT_256;
                    parse_state = PH_GLYPH;
                    close_header();
                end
            end
            PH_V2WORDS: begin
                // Little-endian words; position within the 28 word bytes.
                word_pos = header_pos[4:0] - 5'd4;
                word_buf = word_buf | ({24'd0, b} << (8 * word_pos[1:0]));
                if (word_pos[1:0] == 2'd3) begin
                    case (word_pos[4:2])
                        WORD_HDR_SIZE:
                            header_size = (word_buf > 32'hFFFF) ? 16'hFFFF : word_buf[15:0];
                        WORD_COUNT:
                            glyph_total = (word_buf > 32'hFFFF) ? 16'hFFFF : word_buf[15:0];
                        WORD_BPG:
                            glyph_size = (word_buf > 32'hFFFF) ? 16'hFFFF : word_buf[15:0];
                        WORD_HEIGHT:
                            glyph_rows = (word_buf > 32'hFF) ? 8'hFF : word_buf[7:0];
                        WORD_WIDTH:
                            glyph_cols = (word_buf > 32'hFF) ? 8'hFF : word_buf[7:0];
                        default: ;
                    endcase
                    word_buf = '0;
                end
                header_pos = header_pos + 16'd1;
                if (header_pos >= V2_HDR_END) begin
                    // A stated size at or below 32 cannot rewind the stream.
                    parse_state = (header_size > V2_HDR_END) ? PH_SKIP : PH_GLYPH;
                    close_header();
                end
            end
            PH_SKIP: begin
                header_pos = header_pos + 16'd1;
                if (header_pos >= header_size)
                    parse_state = PH_GLYPH;
            end
            PH_GLYPH: begin
                // MSB first; columns at or past the width are row padding.
                for (int j = 0; j < 8; j++) begin
                    if (int'(row_byte) * 8 + j < int'(glyph_cols))
                        add_expected(KIND_PIXEL, b[7 - j] ? fill_shadow : clear_shadow,
                                     '0, '0, '0,
                                     (j == 7) || (int'(row_byte) * 8 + j + 1 >=
                                                  int'(glyph_cols)));
                end
                glyph_byte = glyph_byte + 16'd1;
                row_byte   = row_byte + 8'd1;
                if (row_stride == 8'd0 || row_byte >= row_stride)
                    row_byte = '0;
                if (glyph_byte >= glyph_size) begin
                    glyph_byte = '0;
                    row_byte   = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one byte and waits for its transfer. push is left high after the
    // transfer so that a back-to-back byte needs no second assignment.
    task automatic send_font_byte(input logic [7:0] value, input logic first);
        int gap;
        gap = draw_wait(FEED_SIDE);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_data_byte     <= value;
        i_start_of_file <= first;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        expand_font_byte(value, first);
    endtask

    task automatic send_file(input logic mark_start);
        foreach (file_bytes[i])
            send_font_byte(file_bytes[i], mark_start && (i == 0));
        file_bytes.delete();
    endtask

    // Magic, seven header words and any skip bytes up to the stated size.
    task automatic add_psf2_header(input logic [31:0] hsize, input logic [31:0] count,
                                   input logic [31:0] bpg, input logic [31:0] height,
                                   input logic [31:0] width);
        logic [31:0] words[7];
        int unsigned skip_end;
        file_bytes = '{PSF2_MAGIC0, PSF2_MAGIC1, PSF2_MAGIC2, PSF2_MAGIC3};
        words = '{$urandom, hsize, $urandom, count, bpg, height, width};
        for (int w = 0; w < 7; w++)
            for (int k = 0; k < 4; k++)
                file_bytes.push_back(words[w][8 * k +: 8]);
        skip_end = (hsize > 32'hFFFF) ? 32'hFFFF : hsize;
        for (int unsigned p = 32; p < skip_end; p++)
            file_bytes.push_back(8'($urandom));
    endtask

    // Drops push, waits for every owed result, then lets the block settle so
    // that bytes which produce nothing have left the pipeline too.
    task automatic wait_until_drained();
        push <= 1'b0;
        while (predicted_font_items.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both colour registers back to back: setup and access per write.
    task automatic set_colours(input logic [31:0] fill, input logic [31:0] clear);
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {(r == 0) ? REG_FILL : REG_CLEAR, 2'b00};
            pwdata  <= (r == 0) ? fill : clear;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fill_shadow  = fill;
        clear_shadow = clear;
    endtask

    // The first file goes in without a start marker, so it relies on reset
    // having put the parser in the magic check. Colours are still at reset.
    task automatic test_reset_defaults();
        file_bytes = '{PSF1_MAGIC0, PSF1_MAGIC1, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hA5, 8'hC3};
        send_file(1'b0);
    endtask

    // A wrong byte at every magic position, and bytes after a bad magic that
    // must be ignored until the next start of file.
    task automatic test_bad_magic();
        file_bytes = '{8'h00, PSF1_MAGIC1};
        send_file(1'b1);
        file_bytes = '{PSF1_MAGIC0, 8'h05};
        send_file(1'b1);
        file_bytes = '{PSF2_MAGIC0, PSF1_MAGIC1};
        send_file(1'b1);
        file_bytes = '{PSF2_MAGIC0, PSF2_MAGIC1, 8'h00, PSF2_MAGIC3};
        send_file(1'b1);
        file_bytes = '{PSF2_MAGIC0, PSF2_MAGIC1, PSF2_MAGIC2, 8'hFF, PSF1_MAGIC0, PSF1_MAGIC1};
        send_file(1'b1);
    endtask

    // PSF1 with 512 glyphs, with 256 glyphs although other mode bits are set,
    // and a zero character size, which gives zero height and zero glyph size.
    task automatic test_psf1_modes();
        file_bytes = '{PSF1_MAGIC0, PSF1_MAGIC1, 8'h01, 8'h03, 8'h81, 8'h7E, 8'h00};
        send_file(1'b1);
        file_bytes = '{PSF1_MAGIC0, PSF1_MAGIC1, 8'hFE, 8'h01, 8'hFF};
        send_file(1'b1);
        file_bytes = '{PSF1_MAGIC0, PSF1_MAGIC1, 8'hFF, 8'h00, 8'h3C, 8'hC3};
        send_file(1'b1);
    endtask

    // PSF2 corner cases. The first file has a header size below 32, a glyph
    // count and glyph size that overflow 16 bits, and a width that overflows
    // 8 bits; with height 1 the row quotient saturates too. The second file
    // skips two header bytes, saturates the height, and has a width of 3, so
    // later bytes of each row lie entirely in padding and yield nothing.
    task automatic test_psf2_limits();
        add_psf2_header(32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'd1, 32'h0000_01FF);
        file_bytes.push_back(8'h80);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'h5A);
        send_file(1'b1);
        add_psf2_header(32'd34, 32'd7, 32'h0000_0300, 32'h0000_0100, 32'd3);
        file_bytes.push_back(8'hE0);
        file_bytes.push_back(8'h1F);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hA0);
        send_file(1'b1);
    endtask

    // A header size beyond 16 bits saturates instead of wrapping. Its low half
    // alone would be below 32 and start glyph data at once; the saturated size
    // keeps the parser skipping, so the bytes after the header yield nothing.
    // The file is cut short and the next start of file ends the skip.
    task automatic test_long_header_skip();
        add_psf2_header(32'h0001_0010, 32'd2, 32'd8, 32'd8, 32'd8);
        while (file_bytes.size() > 40)
            file_bytes.delete(file_bytes.size() - 1);
        send_file(1'b1);
    endtask

    // Mostly well-formed files with random content, some truncated by the
    // next start of file, mixed with broken magics and raw noise.
    task automatic test_random_files(input int unsigned item_budget);
        int unsigned stop_at;
        int unsigned choice;
        int unsigned n;
        logic [31:0] hsize;
        stop_at = bytes_sent + item_budget;
        while (bytes_sent < stop_at) begin
            choice = $urandom_range(0, 9);
            if (choice == 0) begin
                // Noise, with a start of file on some bytes.
                repeat ($urandom_range(1, 5))
                    send_font_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                if (choice == 1) begin
                    // A valid magic with one byte corrupted, then trailing bytes.
                    if ($urandom_range(0, 1) == 0)
                        file_bytes = '{PSF1_MAGIC0, PSF1_MAGIC1};
                    else
                        file_bytes = '{PSF2_MAGIC0, PSF2_MAGIC1, PSF2_MAGIC2, PSF2_MAGIC3};
                    n = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[n] = file_bytes[n] ^ 8'($urandom_range(1, 255));
                    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
                end else if (choice < 6) begin
                    file_bytes = '{PSF1_MAGIC0, PSF1_MAGIC1};
                    file_bytes.push_back(8'($urandom));
                    file_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                     : 8'($urandom_range(1, 4)));
                    repeat ($urandom_range(0, 12)) file_bytes.push_back(8'($urandom));
                end else begin
                    hsize = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(32, 36);
                    add_psf2_header(hsize, pick_field(600), pick_field(6), pick_field(4),
                                    pick_field(20));
                    repeat ($urandom_range(0, 12)) file_bytes.push_back(8'($urandom));
                end
                // Now and then the file is cut short by the next one.
                if (choice >= 2 && $urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, file_bytes.size());
                    while (file_bytes.size() > n)
                        file_bytes.delete(file_bytes.size() - 1);
                end
                send_file(1'b1);
            end
        end
    endtask

    // Result side: random stalls before each transfer, then the transferred
    // result is compared field by field with the oldest owed result.
    initial begin : result_checker
        t_font_item want;
        int         stall;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(DRAIN_SIDE);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (predicted_font_items.size() == 0) begin
                report_mismatch("unexpected result kind", 32'(o_item_kind), '0);
            end else begin
                want = predicted_font_items.pop_front();
                if (o_item_kind !== want.kind)
                    report_mismatch("item_kind", 32'(o_item_kind), 32'(want.kind));
                if (o_pixel_value !== want.pixel)
                    report_mismatch("pixel_value", o_pixel_value, want.pixel);
                if (o_glyph_width !== want.width)
                    report_mismatch("glyph_width", 32'(o_glyph_width), 32'(want.width));
                if (o_glyph_height !== want.height)
                    report_mismatch("glyph_height", 32'(o_glyph_height), 32'(want.height));
                if (o_glyph_count !== want.count)
                    report_mismatch("glyph_count", 32'(o_glyph_count), 32'(want.count));
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", 32'(o_last_of_run), 32'(want.last));
            end
        end
    end

    // Stimulus sequence. Colour registers only change once the block is idle.
    initial begin : stimulus
        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        i_data_byte     <= '0;
        i_start_of_file <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        fill_shadow  = FILL_RESET;
        clear_shadow = CLEAR_RESET;
        clear_font_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        wait_until_drained();
        set_colours(32'h0000_0000, 32'hFFFF_FFFF);
        test_bad_magic();
        test_psf1_modes();
        test_psf2_limits();
        test_long_header_skip();

        // Random traffic under several colour settings.
        wait_until_drained();
        set_colours($urandom, $urandom);
        test_random_files(50);
        wait_until_drained();
        set_colours(32'h0000_0001, 32'h8000_0000);
        test_random_files(50);
        wait_until_drained();
        set_colours($urandom, $urandom);
        test_random_files(50);
        wait_until_drained();
        set_colours(32'hFFFF_FFFF, 32'h0000_0000);
        test_random_files(50);

        wait_until_drained();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
